// ===== design/stmt_pkg.sv =====
// stmt_pkg: widths, codes and table size shared by the stalled task monitor table
// used by stalled_task_monitor_table_unit; the generic ram takes no package
`default_nettype none

package stmt_pkg;

  // table size and derived widths
  localparam int SLOTS    = 16;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int SCAN_W   = $clog2(SLOTS + 1);

  // field widths
  localparam int ID_W       = 22;
  localparam int SC_W       = 32;
  localparam int REC_W      = ID_W + SC_W;
  localparam int NAME_SLOTS = 16;
  localparam int NC_W       = 4;
  localparam int VERD_W     = 4;
  localparam int SLOT_W     = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DETECT_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIST_MODE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNINGS_ON   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PANIC_ON      = 3'd4;

  // list modes
  localparam logic [1:0] LM_NONE  = 2'd0;
  localparam logic [1:0] LM_WHITE = 2'd1;
  localparam logic [1:0] LM_BLACK = 2'd2;

  // verdict codes
  localparam logic [VERD_W-1:0] V_DISABLED    = 4'd0;
  localparam logic [VERD_W-1:0] V_NOT_CHECKED = 4'd1;
  localparam logic [VERD_W-1:0] V_SKIPPED     = 4'd2;
  localparam logic [VERD_W-1:0] V_TABLE_FULL  = 4'd3;
  localparam logic [VERD_W-1:0] V_PROGRESS    = 4'd4;
  localparam logic [VERD_W-1:0] V_HUNG_SILENT = 4'd5;
  localparam logic [VERD_W-1:0] V_HUNG_REPORT = 4'd6;
  localparam logic [VERD_W-1:0] V_HUNG_PANIC  = 4'd7;
  localparam logic [VERD_W-1:0] V_CLEARED     = 4'd8;

endpackage

`default_nettype wire

// ===== design/stalled_task_monitor_table_unit.sv =====
// stalled_task_monitor_table_unit: top level of the stalled task monitor table
// depends on stmt_pkg and two stmt_ram instances (watch ids, record ids with counts)
//
// Usage: one request on the input channel per visited task (or one clear request).
// Every input request yields exactly one result request on the output channel.
// Both channels use valid and stall; a request moves on an edge with valid high
// and stall low. Configuration is a plain write port (enable, index, data).
// Sequencing: one request is worked on at a time by a sequencer around two rams with
// registered reads. Clear and disabled visits pass from idle to the emit state.
// An enabled visit runs through a bind step per bindable watch slot, a check step,
// the watch list walk and the record table scan, then hands the result over; each
// occupied table slot costs a ram read and a compare state. Free or unbound slots
// need no ram read.
// Reset: control and configuration registers and the table valid bits clear at once, so the
// tables read as empty; there is no clearing pass. A clear request empties them
// the same way. The output register holds a result while the receiver stalls; the
// next request is taken meanwhile and waits at the end of its work for the slot.
`default_nettype none

module stalled_task_monitor_table_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [stmt_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [stmt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              in_kind_i,
  input  logic [stmt_pkg::ID_W-1:0]         in_task_id_i,
  input  logic [stmt_pkg::ID_W-1:0]         in_group_id_i,
  input  logic [stmt_pkg::SC_W-1:0]         in_switch_count_i,
  input  logic                              in_frozen_or_skip_i,
  input  logic                              in_uninterruptible_i,
  input  logic [stmt_pkg::NAME_SLOTS-1:0]   in_name_match_mask_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [stmt_pkg::VERD_W-1:0]       out_verdict_o,
  output logic [stmt_pkg::SLOT_W-1:0]       out_record_slot_o,
  output logic [stmt_pkg::ID_W-1:0]         out_reported_id_o
);

  import stmt_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_BIND = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_WREQ = 4'd3;
  localparam logic [3:0] S_WCMP = 4'd4;
  localparam logic [3:0] S_RREQ = 4'd5;
  localparam logic [3:0] S_RCMP = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;

  // configuration registers
  logic            detect_enable_q;
  logic [1:0]      list_mode_q;
  logic [NC_W-1:0] name_count_q;
  logic            warnings_on_q;
  logic            panic_on_q;

  // control state
  logic [3:0]       state_q, state_d;
  logic [SCAN_W-1:0] i_q, i_d;
  logic [NC_W-1:0]  b_q, b_d;
  logic [IDX_W-1:0] free_q, free_d;
  logic             free_ok_q, free_ok_d;
  logic [SLOTS-1:0] wnz_q, wnz_d;
  logic [SLOTS-1:0] rnz_q, rnz_d;
  logic             out_valid_q, out_valid_d;

  // latched request payload
  logic [ID_W-1:0]       id_q;
  logic [ID_W-1:0]       grp_q;
  logic [SC_W-1:0]       cnt_q;
  logic                  frozen_q;
  logic                  unint_q;
  logic [NAME_SLOTS-1:0] mask_q;

  // pending result and output register
  logic [VERD_W-1:0] res_verd_q, res_verd_d;
  logic [IDX_W-1:0]  res_slot_q, res_slot_d;
  logic [VERD_W-1:0] out_verd_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [ID_W-1:0]   out_id_q;

  // ram ports
  logic             watch_we, watch_re;
  logic [IDX_W-1:0] watch_waddr;
  logic [ID_W-1:0]  watch_rdata;
  logic             rec_we, rec_re;
  logic [IDX_W-1:0] rec_waddr;
  logic [REC_W-1:0] rec_rdata;
  logic [ID_W-1:0]  rec_rid;
  logic [SC_W-1:0]  rec_rcnt;

  logic             in_acc;
  logic             out_load;
  logic [IDX_W-1:0] ridx;
  logic             scan_end;
  logic [NC_W-1:0]  limit;
  logic [VERD_W-1:0] hung_verd;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);
  assign ridx     = i_q[IDX_W-1:0];
  assign scan_end = (i_q == SCAN_W'(SLOTS));
  assign rec_rid  = rec_rdata[REC_W-1:SC_W];
  assign rec_rcnt = rec_rdata[SC_W-1:0];

  // bindable watch slots: name_count capped at the table size
  assign limit = (SLOTS < NAME_SLOTS && name_count_q > NC_W'(SLOTS)) ? NC_W'(SLOTS)
                                                                     : name_count_q;

  // hung verdict from warning and panic switches
  assign hung_verd = !warnings_on_q ? V_HUNG_SILENT :
                     panic_on_q     ? V_HUNG_PANIC  : V_HUNG_REPORT;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_enable_q <= 1'b0;
      list_mode_q     <= LM_NONE;
      name_count_q    <= '0;
      warnings_on_q   <= 1'b1;
      panic_on_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DETECT_ENABLE: detect_enable_q <= cfg_data_i[0];
        CFG_LIST_MODE:     list_mode_q     <= cfg_data_i[1:0];
        CFG_NAME_COUNT:    name_count_q    <= NC_W'(cfg_data_i);
        CFG_WARNINGS_ON:   warnings_on_q   <= cfg_data_i[0];
        CFG_PANIC_ON:      panic_on_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    b_d         = b_q;
    free_d      = free_q;
    free_ok_d   = free_ok_q;
    wnz_d       = wnz_q;
    rnz_d       = rnz_q;
    res_verd_d  = res_verd_q;
    res_slot_d  = res_slot_q;
    watch_we    = 1'b0;
    watch_re    = 1'b0;
    watch_waddr = IDX_W'(b_q);
    rec_we      = 1'b0;
    rec_re      = 1'b0;
    rec_waddr   = ridx;
    out_valid_d = out_load || (out_valid_q && out_stall_i);

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_slot_d = '0;
          if (in_kind_i) begin
            wnz_d      = '0;
            rnz_d      = '0;
            res_verd_d = V_CLEARED;
            state_d    = S_EMIT;
          end else if (!detect_enable_q) begin
            res_verd_d = V_DISABLED;
            state_d    = S_EMIT;
          end else begin
            b_d     = '0;
            state_d = S_BIND;
          end
        end
      end

      // bind matched watch slots to the task id, one slot a cycle
      S_BIND: begin
        if (b_q == limit) begin
          state_d = S_CHECK;
        end else begin
          if (mask_q[b_q]) begin
            watch_we           = 1'b1;
            wnz_d[IDX_W'(b_q)] = (id_q != '0);
          end
          b_d = b_q + 1'b1;
        end
      end

      // state and list filters that need no table
      S_CHECK: begin
        i_d       = '0;
        free_ok_d = 1'b0;
        if (!unint_q) begin
          res_verd_d = V_NOT_CHECKED;
          state_d    = S_EMIT;
        end else if (frozen_q || cnt_q == '0 || list_mode_q == LM_NONE ||
                     (list_mode_q == LM_WHITE && name_count_q == '0)) begin
          res_verd_d = V_SKIPPED;
          state_d    = S_EMIT;
        end else if (list_mode_q == LM_WHITE || list_mode_q == LM_BLACK) begin
          state_d = S_WREQ;
        end else begin
          state_d = S_RREQ;
        end
      end

      // watch list walk up to the first match or the first unbound slot
      S_WREQ: begin
        if (scan_end || !wnz_q[ridx]) begin
          i_d = '0;
          if (list_mode_q == LM_WHITE) begin
            res_verd_d = V_SKIPPED;
            state_d    = S_EMIT;
          end else begin
            state_d = S_RREQ;
          end
        end else begin
          watch_re = 1'b1;
          state_d  = S_WCMP;
        end
      end

      S_WCMP: begin
        if (watch_rdata == id_q ||
            (list_mode_q == LM_WHITE && watch_rdata == grp_q)) begin
          i_d = '0;
          if (list_mode_q == LM_WHITE) begin
            state_d = S_RREQ;
          end else begin
            res_verd_d = V_SKIPPED;
            state_d    = S_EMIT;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_WREQ;
        end
      end

      // record table scan: note the first free entry, stop at a hit
      S_RREQ: begin
        if (scan_end) begin
          if (free_ok_q) begin
            rec_we            = 1'b1;
            rec_waddr         = free_q;
            rnz_d[free_q]     = (id_q != '0);
            res_verd_d        = V_PROGRESS;
            res_slot_d        = free_q;
          end else begin
            res_verd_d = V_TABLE_FULL;
            res_slot_d = '0;
          end
          state_d = S_EMIT;
        end else if (!rnz_q[ridx]) begin
          if (!free_ok_q) begin
            free_d    = ridx;
            free_ok_d = 1'b1;
          end
          i_d = i_q + 1'b1;
        end else begin
          rec_re  = 1'b1;
          state_d = S_RCMP;
        end
      end

      S_RCMP: begin
        if (rec_rid == id_q) begin
          res_slot_d = ridx;
          if (rec_rcnt != cnt_q) begin
            rec_we     = 1'b1;
            res_verd_d = V_PROGRESS;
          end else begin
            res_verd_d = hung_verd;
          end
          state_d = S_EMIT;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_RREQ;
        end
      end

      // hand the result to the output register once it is free
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      b_q         <= '0;
      free_q      <= '0;
      free_ok_q   <= 1'b0;
      wnz_q       <= '0;
      rnz_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      b_q         <= b_d;
      free_q      <= free_d;
      free_ok_q   <= free_ok_d;
      wnz_q       <= wnz_d;
      rnz_q       <= rnz_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request payload latch
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      id_q     <= in_task_id_i;
      grp_q    <= in_group_id_i;
      cnt_q    <= in_switch_count_i;
      frozen_q <= in_frozen_or_skip_i;
      unint_q  <= in_uninterruptible_i;
      mask_q   <= in_name_match_mask_i;
    end
  end

  // pending result and output payload
  always_ff @(posedge clk_i) begin
    res_verd_q <= res_verd_d;
    res_slot_q <= res_slot_d;
    if (out_load) begin
      out_verd_q <= res_verd_q;
      out_slot_q <= SLOT_W'(res_slot_q);
      out_id_q   <= id_q;
    end
  end

  // watch id store
  stmt_ram #(
    .WIDTH (ID_W),
    .DEPTH (SLOTS)
  ) u_watch_ram (
    .clk_i   (clk_i),
    .we_i    (watch_we),
    .waddr_i (watch_waddr),
    .wdata_i (id_q),
    .re_i    (watch_re),
    .raddr_i (ridx),
    .rdata_o (watch_rdata)
  );

  // record store: task id with its last switch count
  stmt_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i ({id_q, cnt_q}),
    .re_i    (rec_re),
    .raddr_i (ridx),
    .rdata_o (rec_rdata)
  );

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign out_verdict_o     = out_verd_q;
  assign out_record_slot_o = out_slot_q;
  assign out_reported_id_o = out_id_q;

  // a clear request empties both tables on the next edge
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_kind_i) |=> (wnz_q == '0 && rnz_q == '0))
    else $error("tables not empty after clear request");

  // record ram is never read and written in the same cycle
  a_rec_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rec_we && rec_re))
    else $error("record ram read and write overlap");

  // only table verdicts carry a slot number
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_verdict_o == V_DISABLED || out_verdict_o == V_NOT_CHECKED ||
     out_verdict_o == V_SKIPPED || out_verdict_o == V_TABLE_FULL ||
     out_verdict_o == V_CLEARED)) |-> (out_record_slot_o == '0))
    else $error("slot set on a verdict without a table entry");

  // a hung task always has a nonzero id; id zero never gets a hung verdict
  a_hung_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_verdict_o == V_HUNG_SILENT || out_verdict_o == V_HUNG_REPORT ||
     out_verdict_o == V_HUNG_PANIC)) |-> (out_reported_id_o != '0))
    else $error("hung verdict for task id zero");

  // a new result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && out_stall_i) |=> (state_q == S_EMIT))
    else $error("result left the sequencer while output was stalled");

endmodule

`default_nettype wire

// ===== design/stmt_ram.sv =====
// stmt_ram: generic single write port, single read port ram with registered read
// depends on nothing; width and depth come from parameters
`default_nettype none

module stmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
